>>> hdl/assert_macros.svh
// Assertion macros shared by the compensation core RTL.
// Both macros expect signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define BPTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checks that an antecedent implies a consequent in the same cycle.
`define BPTC_ASSERT_IMPL(lbl, ante, cons, msg) \
  `BPTC_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

>>> hdl/bptc_pkg.sv
// Package of the barometric compensation core: word types, register codes
// and fixed constants of the compensation arithmetic. No dependencies.
`timescale 1ns / 1ps

package bptc_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Calibration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_C1 = 3'd0,
    CFG_C2 = 3'd1,
    CFG_C3 = 3'd2,
    CFG_C4 = 3'd3,
    CFG_C5 = 3'd4,
    CFG_C6 = 3'd5
  } cfg_idx_t;

  // Number of register stages from input to output register.
  localparam int NUM_STAGES = 8;

  // Reference temperature, and its distance to the cold threshold.
  localparam logic signed [19:0] TEMP_REF = 20'sd2000;
  localparam logic signed [19:0] COLD_OFS = 20'sd3500;

  // Saturation limits.
  localparam logic signed [20:0] TEMP_LO      = -21'sd4000;
  localparam logic signed [20:0] TEMP_HI      = 21'sd8500;
  localparam logic signed [14:0] TEMP_LO_OUT  = -15'sd4000;
  localparam logic signed [14:0] TEMP_HI_OUT  = 15'sd8500;
  localparam logic signed [29:0] PRES_HI      = 30'sd120000;
  localparam logic [16:0]        PRES_HI_OUT  = 17'd120000;

  // Input word: one pair of raw conversions.
  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } in_word_t;

  // Output word: compensated temperature and pressure.
  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic [16:0]        pressure_pa;
    logic               result_valid;
  } out_word_t;

endpackage

>>> hdl/bptc_in_if.sv
// Input channel of the compensation core: valid/ready plus a raw word.
// Depends on bptc_pkg.
`timescale 1ns / 1ps

interface bptc_in_if;
  import bptc_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/bptc_out_if.sv
// Result channel of the compensation core: valid/ready plus a result word.
// Depends on bptc_pkg.
`timescale 1ns / 1ps

interface bptc_out_if;
  import bptc_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/baro_pressure_temp_compensation_core.sv
// Second-order barometric compensation core: top level and only module.
// Depends on bptc_pkg, bptc_in_if, bptc_out_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The core takes one word of raw pressure and temperature conversions and
// returns the compensated temperature in hundredths of a degree and the
// pressure in pascals, both saturated, using the six calibration words
// written through the cfg port (write them while no word is in flight).
// It is an eight-stage pipeline: a word can be accepted every clock cycle
// while the output is not stalled, and its result passes through stages 0
// to 6 into the output register, stage 7. Each stage holds a valid bit and
// loads whenever it is empty or the stage after it can take its word, so
// bubbles close up and a stalled result does not block input until all eight
// stages are full. A word with a zero raw value yields result_valid low and zero fields.
module baro_pressure_temp_compensation_core (
  input  logic                          clk,
  input  logic                          rst_n,
  bptc_in_if.sink                       in_ch,
  bptc_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [bptc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bptc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bptc_pkg::*;

  // Calibration registers.
  logic [15:0] c1_r, c2_r, c3_r, c4_r, c5_r, c6_r;

  // Pipeline control.
  logic [NUM_STAGES-1:0] v_r, v_nxt, en, v_in;

  // Stage 0: dT.
  logic [23:0]        d1_s0_r;
  logic signed [24:0] dt_s0_r, dt_nxt;
  logic               ok_s0_r;
  // Stage 1: first-order products.
  logic [23:0]        d1_s1_r;
  logic signed [41:0] pt_s1_r, p4_s1_r, p3_s1_r, pt_nxt, p4_nxt, p3_nxt;
  logic signed [49:0] dd_s1_r, dd_nxt;
  logic               ok_s1_r;
  // Stage 2: temperature, offset and sensitivity.
  logic [23:0]        d1_s2_r;
  logic signed [18:0] dw_s2_r, dw_nxt;
  logic signed [19:0] dc_s2_r, dc_nxt, temp_s2_r, temp_nxt;
  logic signed [35:0] off_s2_r, off_nxt;
  logic signed [34:0] sens_s2_r, sens_nxt;
  logic [17:0]        t2_s2_r;
  logic               ok_s2_r;
  // Stage 3: squares for the second-order terms.
  logic [23:0]        d1_s3_r;
  logic [34:0]        sqw_s3_r, sqc_s3_r;
  logic signed [37:0] sqw_full;
  logic signed [39:0] sqc_full;
  logic signed [19:0] temp_s3_r;
  logic signed [35:0] off_s3_r;
  logic signed [34:0] sens_s3_r;
  logic [17:0]        t2_s3_r;
  logic               cool_s3_r, cold_s3_r, ok_s3_r;
  // Stage 4: corrected terms and saturated temperature.
  logic [23:0]        d1_s4_r;
  logic [36:0]        w5;
  logic [37:0]        c7;
  logic [38:0]        c11;
  logic [37:0]        off2, sens2;
  logic signed [20:0] temp_f;
  logic signed [39:0] off_f_nxt, sens_f_nxt, off_s4_r, sens_s4_r;
  logic signed [14:0] temp_c_nxt, temp_s4_r;
  logic               ok_s4_r;
  // Stage 5: partial products of D1 * SENS.
  logic [43:0]        pl_s5_r;
  logic signed [44:0] ph_s5_r, ph_nxt;
  logic signed [39:0] off_s5_r;
  logic signed [14:0] temp_s5_r;
  logic               ok_s5_r;
  // Stage 6: D1 * SENS / 2^21.
  logic signed [64:0] prod;
  logic signed [43:0] x_s6_r;
  logic signed [39:0] off_s6_r;
  logic signed [14:0] temp_s6_r;
  logic               ok_s6_r;
  // Stage 7: output register.
  logic signed [44:0] y;
  logic signed [29:0] p;
  logic [16:0]        p_sat;
  out_word_t          out_r, out_nxt;
  // Terms of the result checks.
  logic               out_invalid, out_zero, out_in_range;

  // Calibration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
      c4_r <= '0;
      c5_r <= '0;
      c6_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_C1:  c1_r <= cfg_wdata;
        CFG_C2:  c2_r <= cfg_wdata;
        CFG_C3:  c3_r <= cfg_wdata;
        CFG_C4:  c4_r <= cfg_wdata;
        CFG_C5:  c5_r <= cfg_wdata;
        CFG_C6:  c6_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or its word moves on.
  always_comb begin
    en[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || out_ch.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_in = {v_r[NUM_STAGES-2:0], in_ch.valid};
    for (int k = 0; k < NUM_STAGES; k++) begin
      v_nxt[k] = en[k] ? v_in[k] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ch.ready  = en[0];
  assign out_ch.valid = v_r[NUM_STAGES-1];
  assign out_ch.data  = out_r;

  // Stage 0: dT = D2 - C5 * 2^8 and the zero check.
  assign dt_nxt = $signed({1'b0, in_ch.data.raw_temperature}) - $signed({1'b0, c5_r, 8'b0});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d1_s0_r <= in_ch.data.raw_pressure;
      dt_s0_r <= dt_nxt;
      ok_s0_r <= (in_ch.data.raw_pressure != '0) && (in_ch.data.raw_temperature != '0);
    end
  end

  // Stage 1: dT * C6, C4 * dT, C3 * dT and dT^2 in parallel.
  assign pt_nxt = dt_s0_r * $signed({1'b0, c6_r});
  assign p4_nxt = dt_s0_r * $signed({1'b0, c4_r});
  assign p3_nxt = dt_s0_r * $signed({1'b0, c3_r});
  assign dd_nxt = dt_s0_r * dt_s0_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      d1_s1_r <= d1_s0_r;
      pt_s1_r <= pt_nxt;
      p4_s1_r <= p4_nxt;
      p3_s1_r <= p3_nxt;
      dd_s1_r <= dd_nxt;
      ok_s1_r <= ok_s0_r;
    end
  end

  // Stage 2: floor shifts are upper part-selects of the products.
  assign dw_nxt   = pt_s1_r[41:23];
  assign temp_nxt = TEMP_REF + {dw_nxt[18], dw_nxt};
  assign dc_nxt   = COLD_OFS + {dw_nxt[18], dw_nxt};
  assign off_nxt  = {4'b0, c2_r, 16'b0} + {p4_s1_r[41], p4_s1_r[41:7]};
  assign sens_nxt = {4'b0, c1_r, 15'b0} + {p3_s1_r[41], p3_s1_r[41:8]};

  always_ff @(posedge clk) begin
    if (en[2]) begin
      d1_s2_r   <= d1_s1_r;
      dw_s2_r   <= dw_nxt;
      dc_s2_r   <= dc_nxt;
      temp_s2_r <= temp_nxt;
      off_s2_r  <= off_nxt;
      sens_s2_r <= sens_nxt;
      t2_s2_r   <= dd_s1_r[48:31];
      ok_s2_r   <= ok_s1_r;
    end
  end

  // Stage 3: squares of the distances to 20.00 and -15.00 degrees.
  assign sqw_full = dw_s2_r * dw_s2_r;
  assign sqc_full = dc_s2_r * dc_s2_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      d1_s3_r   <= d1_s2_r;
      sqw_s3_r  <= sqw_full[34:0];
      sqc_s3_r  <= sqc_full[34:0];
      temp_s3_r <= temp_s2_r;
      off_s3_r  <= off_s2_r;
      sens_s3_r <= sens_s2_r;
      t2_s3_r   <= t2_s2_r;
      cool_s3_r <= dw_s2_r[18];
      cold_s3_r <= dc_s2_r[19];
      ok_s3_r   <= ok_s2_r;
    end
  end

  // Stage 4: second-order corrections by shift-and-add, then temperature
  // saturation.
  always_comb begin
    w5    = {sqw_s3_r, 2'b0} + {2'b0, sqw_s3_r};
    c7    = {sqc_s3_r, 3'b0} - {3'b0, sqc_s3_r};
    c11   = {1'b0, sqc_s3_r, 3'b0} + {3'b0, sqc_s3_r, 1'b0} + {4'b0, sqc_s3_r};
    off2  = {2'b0, w5[36:1]};
    sens2 = {3'b0, w5[36:2]};
    if (cold_s3_r) begin
      off2  = off2 + c7;
      sens2 = sens2 + c11[38:1];
    end
    temp_f     = {temp_s3_r[19], temp_s3_r};
    off_f_nxt  = {{4{off_s3_r[35]}}, off_s3_r};
    sens_f_nxt = {{5{sens_s3_r[34]}}, sens_s3_r};
    if (cool_s3_r) begin
      temp_f     = temp_f - {3'b0, t2_s3_r};
      off_f_nxt  = off_f_nxt - {2'b0, off2};
      sens_f_nxt = sens_f_nxt - {2'b0, sens2};
    end
    if (temp_f < TEMP_LO) begin
      temp_c_nxt = TEMP_LO_OUT;
    end else if (temp_f > TEMP_HI) begin
      temp_c_nxt = TEMP_HI_OUT;
    end else begin
      temp_c_nxt = temp_f[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      d1_s4_r   <= d1_s3_r;
      temp_s4_r <= temp_c_nxt;
      off_s4_r  <= off_f_nxt;
      sens_s4_r <= sens_f_nxt;
      ok_s4_r   <= ok_s3_r;
    end
  end

  // Stage 5: D1 times the low and high halves of SENS.
  assign ph_nxt = $signed({1'b0, d1_s4_r}) * $signed(sens_s4_r[39:20]);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      pl_s5_r   <= d1_s4_r * sens_s4_r[19:0];
      ph_s5_r   <= ph_nxt;
      off_s5_r  <= off_s4_r;
      temp_s5_r <= temp_s4_r;
      ok_s5_r   <= ok_s4_r;
    end
  end

  // Stage 6: recombine the partial products and shift by 2^21.
  assign prod = {ph_s5_r, 20'b0} + {21'b0, pl_s5_r};

  always_ff @(posedge clk) begin
    if (en[6]) begin
      x_s6_r    <= prod[64:21];
      off_s6_r  <= off_s5_r;
      temp_s6_r <= temp_s5_r;
      ok_s6_r   <= ok_s5_r;
    end
  end

  // Stage 7: subtract OFF, shift by 2^15 and saturate the pressure.
  always_comb begin
    y = {x_s6_r[43], x_s6_r} - {{5{off_s6_r[39]}}, off_s6_r};
    p = y[44:15];
    if (p[29]) begin
      p_sat = '0;
    end else if (p > PRES_HI) begin
      p_sat = PRES_HI_OUT;
    end else begin
      p_sat = p[16:0];
    end
    out_nxt.temperature_centi = ok_s6_r ? temp_s6_r : '0;
    out_nxt.pressure_pa       = ok_s6_r ? p_sat : '0;
    out_nxt.result_valid      = ok_s6_r;
  end

  always_ff @(posedge clk) begin
    if (en[NUM_STAGES-1]) begin
      out_r <= out_nxt;
    end
  end

  // Terms used by the result checks below.
  assign out_invalid  = out_ch.valid && !out_ch.data.result_valid;
  assign out_zero     = (out_ch.data.temperature_centi == '0) &&
                        (out_ch.data.pressure_pa == '0);
  assign out_in_range = ($signed(out_ch.data.temperature_centi) >= TEMP_LO_OUT) &&
                        ($signed(out_ch.data.temperature_centi) <= TEMP_HI_OUT) &&
                        (out_ch.data.pressure_pa <= PRES_HI_OUT);

  // An invalid result carries zero fields.
  `BPTC_ASSERT_IMPL(a_invalid_zero, out_invalid, out_zero, "invalid result with nonzero fields")

  // Results always lie within their saturation ranges.
  `BPTC_ASSERT_IMPL(a_out_range, out_ch.valid, out_in_range, "result outside saturation range")

  // Input is refused only when every stage holds a word.
  `BPTC_ASSERT_IMPL(a_full_on_stall, !in_ch.ready, &v_r, "input stalled while a stage is empty")

  // The pipeline comes out of reset empty.
  `BPTC_ASSERT_IMPL(a_reset_empty, !$past(rst_n), v_r == '0, "pipeline not empty after reset")

endmodule
